// File: rtl/hrf_pkg.sv
package hrf_pkg;

  // Field widths
  localparam int unsigned TEMP_W  = 24;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DT_W    = 24;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned NPTS_W  = 8;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_W   = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Register map (index = paddr / 4)
  localparam logic [REG_W-1:0] REG_PAUSED    = 3'd0;
  localparam logic [REG_W-1:0] REG_SOURCE    = 3'd1;
  localparam logic [REG_W-1:0] REG_AMBIENT   = 3'd2;
  localparam logic [REG_W-1:0] REG_RATE      = 3'd3;
  localparam logic [REG_W-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [REG_W-1:0] REG_NPOINTS   = 3'd5;

  // Register reset values
  localparam logic               PAUSED_RST    = 1'b1;
  localparam logic [TEMP_W-1:0]  SOURCE_RST    = 24'd25600;
  localparam logic [TEMP_W-1:0]  AMBIENT_RST   = 24'd5120;
  localparam logic [RATE_W-1:0]  RATE_RST      = 32'd54186;
  localparam logic [DT_W-1:0]    TIME_STEP_RST = 24'd1049;
  localparam logic [NPTS_W-1:0]  NPOINTS_RST   = 8'd100;

  // Gain limits
  localparam logic [35:0] GAIN_HALF = 36'd32768;
  localparam logic [35:0] GAIN_MAX  = 36'd65535;

  // Per-point controls for the update unit
  typedef struct packed {
    logic step;      // a step that is not paused
    logic reload;    // restore the initial profile
    logic head;      // point 0
    logic tail;      // last point in use
    logic interior;  // strictly between head and tail
  } ctl_t;

endpackage

// File: rtl/hrf_cell.sv
module hrf_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             shift_i,
  input  logic [hrf_pkg::TEMP_W-1:0]       d_i,
  output logic [hrf_pkg::TEMP_W-1:0]       q_o
);

  logic [hrf_pkg::TEMP_W-1:0] val_q;

  // One rod point; takes its neighbor's value on every shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= IS_HEAD ? hrf_pkg::SOURCE_RST : hrf_pkg::AMBIENT_RST;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

// File: rtl/hrf_point_unit.sv
module hrf_point_unit (
  input  hrf_pkg::ctl_t                    ctl_i,
  input  logic [hrf_pkg::GAIN_W-1:0]       gain_i,
  input  logic [hrf_pkg::TEMP_W-1:0]       left_i,
  input  logic [hrf_pkg::TEMP_W-1:0]       mid_i,
  input  logic [hrf_pkg::TEMP_W-1:0]       right_i,
  input  logic [hrf_pkg::TEMP_W-1:0]       source_i,
  input  logic [hrf_pkg::TEMP_W-1:0]       ambient_i,
  output logic [hrf_pkg::TEMP_W-1:0]       new_o
);

  logic signed [25:0] lap;
  logic signed [42:0] prod;
  logic signed [26:0] delta;
  logic signed [27:0] sum;
  logic [hrf_pkg::TEMP_W-1:0] upd;

  // Three-point Laplacian; fits in 26 signed bits.
  assign lap = $signed({{2{right_i[23]}}, right_i})
             - $signed({mid_i[23], mid_i, 1'b0})
             + $signed({{2{left_i[23]}}, left_i});

  // Gain times Laplacian, floored by the arithmetic shift.
  assign prod  = $signed({1'b0, gain_i}) * lap;
  assign delta = prod[42:16];
  assign sum   = $signed({{4{mid_i[23]}}, mid_i}) + $signed({delta[26], delta});

  // Saturate to the 24-bit signed range.
  always_comb begin
    if (sum > 28'sd8388607) begin
      upd = 24'h7FFFFF;
    end else if (sum < -28'sd8388608) begin
      upd = 24'h800000;
    end else begin
      upd = sum[23:0];
    end
  end

  // Choose what the point becomes for this command.
  always_comb begin
    new_o = mid_i;
    if (ctl_i.reload) begin
      new_o = ctl_i.head ? source_i : ambient_i;
    end else if (ctl_i.step) begin
      if (ctl_i.head) begin
        new_o = source_i;
      end else if (ctl_i.tail) begin
        new_o = ambient_i;
      end else if (ctl_i.interior) begin
        new_o = upd;
      end
    end
  end

endmodule

// File: rtl/heat_rod_ftcs_step.sv
// Explicit FTCS heat-equation step on a rod of ROD_POINTS Q16.8 temperature
// points. Each point lives in a cell of a circular shift chain; every request
// rotates the whole chain once through a single point-update unit. Any request
// (step, profile reset or read) goes through the states in order: the gain
// multiply, saturation of the gain, the lap that passes every point through
// the update unit, and the hand-over of the result to the output register.
// Requests are taken only in the idle state; a result that waits in the
// output register holds the next one back, and then the request side. The
// requested point is picked off as it passes the update unit. A new request
// is taken once the result has moved into the output register, even if that
// result has not been taken yet. Configuration must be written through the
// APB-style port only while the block is idle; the block itself does not
// enforce this. pready is always high.
module heat_rod_ftcs_step #(
  parameter int unsigned ROD_POINTS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hrf_pkg::CMD_W-1:0]           cmd_i,
  input  logic [hrf_pkg::DT_W-1:0]            delta_time_i,
  input  logic [hrf_pkg::IDX_W-1:0]           point_index_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hrf_pkg::TEMP_W-1:0]          point_temp_o,
  output logic [hrf_pkg::TIME_W-1:0]          elapsed_time_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hrf_pkg::APB_AW-1:0]          paddr,
  input  logic [hrf_pkg::APB_DW-1:0]          pwdata,
  output logic [hrf_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned KW = $clog2(ROD_POINTS);
  localparam int unsigned PW = (KW + 1 > 8) ? KW + 1 : 8;
  localparam int unsigned XW = (KW > hrf_pkg::IDX_W) ? KW : hrf_pkg::IDX_W;
  localparam logic [KW-1:0] LAST_K = KW'(ROD_POINTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GAIN,
    ST_LAP,
    ST_DONE
  } state_e;

  // Configuration registers
  logic                         paused_q;
  logic [hrf_pkg::TEMP_W-1:0]   source_q;
  logic [hrf_pkg::TEMP_W-1:0]   ambient_q;
  logic [hrf_pkg::RATE_W-1:0]   rate_q;
  logic [hrf_pkg::DT_W-1:0]     time_step_q;
  logic [hrf_pkg::NPTS_W-1:0]   npoints_q;

  logic                         cfg_wr;
  logic [hrf_pkg::REG_W-1:0]    cfg_idx;

  // Control and datapath
  state_e                       state_q;
  logic [KW-1:0]                k_q;
  logic [KW-1:0]                last_q;
  logic                         op_step_q;
  logic                         op_reload_q;
  logic [hrf_pkg::DT_W-1:0]     dtime_q;
  logic [hrf_pkg::IDX_W-1:0]    idx_q;
  logic [55:0]                  prod_q;
  logic [hrf_pkg::GAIN_W-1:0]   gain_q;
  logic [hrf_pkg::TEMP_W-1:0]   prev_q;
  logic [hrf_pkg::TEMP_W-1:0]   capt_q;
  logic [hrf_pkg::TIME_W-1:0]   sim_q;
  logic                         out_valid_q;
  logic [hrf_pkg::TEMP_W-1:0]   point_temp_q;
  logic [hrf_pkg::TIME_W-1:0]   elapsed_q;

  logic [hrf_pkg::TEMP_W-1:0]   cell_q [ROD_POINTS];
  logic [hrf_pkg::TEMP_W-1:0]   tail_d;
  logic                         shift;
  hrf_pkg::ctl_t                ctl;

  logic [hrf_pkg::DT_W-1:0]     mul_op;
  logic [35:0]                  gain_raw;
  logic [PW-1:0]                npts_ext;
  logic [PW-1:0]                npts_eff;
  logic [hrf_pkg::TIME_W:0]     sim_sum;
  logic                         hit;
  logic                         accept;

  // Register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[hrf_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q    <= hrf_pkg::PAUSED_RST;
      source_q    <= hrf_pkg::SOURCE_RST;
      ambient_q   <= hrf_pkg::AMBIENT_RST;
      rate_q      <= hrf_pkg::RATE_RST;
      time_step_q <= hrf_pkg::TIME_STEP_RST;
      npoints_q   <= hrf_pkg::NPOINTS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hrf_pkg::REG_PAUSED:    paused_q    <= pwdata[0];
        hrf_pkg::REG_SOURCE:    source_q    <= pwdata[23:0];
        hrf_pkg::REG_AMBIENT:   ambient_q   <= pwdata[23:0];
        hrf_pkg::REG_RATE:      rate_q      <= pwdata;
        hrf_pkg::REG_TIME_STEP: time_step_q <= pwdata[23:0];
        hrf_pkg::REG_NPOINTS:   npoints_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_idx)
      hrf_pkg::REG_PAUSED:    prdata = {31'd0, paused_q};
      hrf_pkg::REG_SOURCE:    prdata = {{8{source_q[23]}}, source_q};
      hrf_pkg::REG_AMBIENT:   prdata = {{8{ambient_q[23]}}, ambient_q};
      hrf_pkg::REG_RATE:      prdata = rate_q;
      hrf_pkg::REG_TIME_STEP: prdata = {8'd0, time_step_q};
      hrf_pkg::REG_NPOINTS:   prdata = {24'd0, npoints_q};
      default:                prdata = '0;
    endcase
  end

  // Points in use, clamped to at least three and at most the rod.
  assign npts_ext = PW'(npoints_q);
  always_comb begin
    if (npts_ext < PW'(3)) begin
      npts_eff = PW'(3);
    end else if (npts_ext > PW'(ROD_POINTS)) begin
      npts_eff = PW'(ROD_POINTS);
    end else begin
      npts_eff = npts_ext;
    end
  end

  // Time used for the gain: fixed step capped by the frame time, or the frame time.
  assign mul_op   = ((time_step_q != '0) && (time_step_q < dtime_q)) ? time_step_q : dtime_q;
  assign gain_raw = prod_q[55:20];

  // Saturating elapsed-time add.
  assign sim_sum = {1'b0, sim_q} + {25'd0, dtime_q};

  // Cell chain: every cell takes its right neighbor, the last takes the update result.
  assign shift = (state_q == ST_LAP);

  for (genvar i = 0; i < ROD_POINTS; i++) begin : g_cell
    if (i == ROD_POINTS - 1) begin : g_tail
      hrf_cell #(.IS_HEAD(1'b0)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .d_i     (tail_d),
        .q_o     (cell_q[i])
      );
    end else begin : g_body
      hrf_cell #(.IS_HEAD(i == 0)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .d_i     (cell_q[i+1]),
        .q_o     (cell_q[i])
      );
    end
  end

  // Controls for the point at the head of the chain.
  assign ctl.step     = op_step_q;
  assign ctl.reload   = op_reload_q;
  assign ctl.head     = (k_q == '0);
  assign ctl.tail     = (k_q == last_q);
  assign ctl.interior = (k_q != '0) && (k_q < last_q);

  hrf_point_unit u_point (
    .ctl_i     (ctl),
    .gain_i    (gain_q),
    .left_i    (prev_q),
    .mid_i     (cell_q[0]),
    .right_i   (cell_q[1]),
    .source_i  (source_q),
    .ambient_i (ambient_q),
    .new_o     (tail_d)
  );

  assign hit    = (XW'(k_q) == XW'(idx_q));
  assign accept = in_valid_i & (state_q == ST_IDLE);

  // Sequencer with result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      last_q       <= '0;
      op_step_q    <= 1'b0;
      op_reload_q  <= 1'b0;
      sim_q        <= '0;
      out_valid_q  <= 1'b0;
      point_temp_q <= '0;
      elapsed_q    <= '0;
    end else begin
      // A result taken while a new one is loaded is replaced, not cleared.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_step_q   <= (cmd_i == hrf_pkg::CMD_STEP) && !paused_q;
            op_reload_q <= (cmd_i == hrf_pkg::CMD_RELOAD);
            last_q      <= KW'(npts_eff - PW'(1));
            k_q         <= '0;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          state_q <= ST_LAP;
        end
        ST_LAP: begin
          k_q <= k_q + KW'(1);
          if (k_q == LAST_K) begin
            if (op_reload_q) begin
              sim_q <= '0;
            end else if (op_step_q) begin
              sim_q <= sim_sum[hrf_pkg::TIME_W] ? '1 : sim_sum[hrf_pkg::TIME_W-1:0];
            end
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            point_temp_q <= capt_q;
            elapsed_q    <= sim_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dtime_q <= delta_time_i;
      idx_q   <= point_index_i;
      capt_q  <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q <= 56'(rate_q) * 56'(mul_op);
    end
    if (state_q == ST_GAIN) begin
      if (time_step_q == '0 && gain_raw > hrf_pkg::GAIN_HALF) begin
        gain_q <= hrf_pkg::GAIN_HALF[15:0];
      end else if (gain_raw > hrf_pkg::GAIN_MAX) begin
        gain_q <= hrf_pkg::GAIN_MAX[15:0];
      end else begin
        gain_q <= gain_raw[15:0];
      end
    end
    if (shift) begin
      prev_q <= cell_q[0];
      if (hit) begin
        capt_q <= tail_d;
      end
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign point_temp_o   = point_temp_q;
  assign elapsed_time_o = elapsed_q;

endmodule
